>>> hdl/sba_pkg.sv
// Package with the request and result types, codes and constants of the slab allocator.
package sba_pkg;

  localparam int PoolPagesDefault = 64;
  localparam int WordsPerPage = 8;
  localparam int WordBits = 32;
  localparam int DataOffset = 44;
  localparam int DataBytes = 4096 - 12 - 32;
  localparam int ClassCount = 7;
  localparam int MaxSize = 1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_FREED = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_BAD_ADDRESS = 3'd4;

  typedef struct packed {
    logic        operation;
    logic [15:0] request_size;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [31:0] address;
    logic [2:0]  status;
  } rsp_t;

  // Slots per page for a class: floor(4052 / (16 << cls)).
  function automatic logic [8:0] slot_count(input logic [2:0] cls);
    logic [8:0] n;
    begin
      case (cls)
        3'd0: n = 9'd253;
        3'd1: n = 9'd126;
        3'd2: n = 9'd63;
        3'd3: n = 9'd31;
        3'd4: n = 9'd15;
        3'd5: n = 9'd7;
        3'd6: n = 9'd3;
        default: n = 9'd0;
      endcase
      return n;
    end
  endfunction

  function automatic logic [2:0] class_of_size(input logic [15:0] size);
    logic [2:0] c;
    begin
      if (size <= 16'd16) c = 3'd0;
      else if (size <= 16'd32) c = 3'd1;
      else if (size <= 16'd64) c = 3'd2;
      else if (size <= 16'd128) c = 3'd3;
      else if (size <= 16'd256) c = 3'd4;
      else if (size <= 16'd512) c = 3'd5;
      else c = 3'd6;
      return c;
    end
  endfunction

endpackage

>>> hdl/sba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/sba_datapath.sv
// Datapath of the slab allocator: page class and bitmap memories, scan registers, address math.
module sba_datapath #(
  parameter int POOL_PAGES = sba_pkg::PoolPagesDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  input  logic              cmd_load,      // capture request, start scan
  input  logic              cmd_cls_rd,    // present class read of page_r
  input  logic              cmd_word_rd,   // present bitmap read of page_r/word_r
  input  logic              cmd_eval,      // examine returned bitmap word
  input  logic              cmd_next_page,
  input  logic              cmd_claim,     // claim new page (one word per call)
  input  logic              cmd_take,      // write found bit and form result
  input  logic              cmd_free,      // clear bit of free address
  input  logic              cmd_reject,
  input  logic [2:0]        cmd_status,
  input  sba_pkg::req_t     req,
  output logic              st_too_large,
  output logic              st_free_bad,
  output logic              st_page_none,  // no more pages to scan
  output logic              st_cls_match,
  output logic              st_found,
  output logic              st_word_last,
  output logic              st_full,
  output logic              st_claim_done,
  output sba_pkg::rsp_t     rsp
);

  localparam int PW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int CW = $clog2(POOL_PAGES + 1);
  localparam int BD = POOL_PAGES * sba_pkg::WordsPerPage;
  localparam int BW = $clog2(BD);

  logic [31:0] base_r;
  logic [CW-1:0] used_r, used_nxt;
  logic [2:0] cls_r;
  logic [CW-1:0] page_r;      // scan page plus one (0 means done)
  logic [2:0] word_r;
  logic [8:0] slot_r;
  logic [31:0] word_q;
  logic [2:0] cls_q;
  logic [4:0] bit_r;
  logic [31:0] faddr_r;
  logic [31:0] rel;
  logic [31:0] rel_in;
  logic [11:0] off;
  logic [11:0] doff;
  logic [8:0] fslot;
  logic [CW-1:0] fpage;
  logic [PW-1:0] cur_page;
  logic [4:0] fbit;
  logic found_c;
  logic [4:0] fb_c;
  logic [31:0] valid_mask;
  logic [8:0] cnt;
  logic [8:0] base_slot;

  // Memories.
  logic c_we, b_we;
  logic [PW-1:0] c_waddr, c_raddr;
  logic [2:0] c_wdata;
  logic [BW-1:0] b_waddr, b_raddr;
  logic [31:0] b_wdata;

  sba_ram #(.WIDTH(3), .DEPTH(POOL_PAGES)) u_cls (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(cls_q));

  sba_ram #(.WIDTH(32), .DEPTH(BD)) u_bmp (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(word_q));

  assign cur_page = (PW)'(page_r - CW'(1));
  assign rel = faddr_r - base_r;
  // The page of a free is needed at the accepting edge, so it comes from the live request.
  assign rel_in = req.free_address - base_r;
  assign off = rel[11:0];
  assign doff = off - 12'(sba_pkg::DataOffset);
  assign fpage = (rel_in[31:12] < 20'(POOL_PAGES)) ? CW'(rel_in[31:12]) : CW'(POOL_PAGES);
  assign st_free_bad = (rel[31:12] >= 20'(used_r)) || (off < 12'(sba_pkg::DataOffset));
  assign fslot = 9'(doff >> (4'd4 + 4'(cls_q)));
  assign fbit = fslot[4:0];
  assign cnt = sba_pkg::slot_count(cls_r);
  assign base_slot = {1'b0, word_r, 5'd0};

  // Slots in this word that exist.
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      valid_mask[i] = (9'(base_slot + 9'(i)) < cnt);
    end
  end

  always_comb begin
    found_c = 1'b0;
    fb_c = '0;
    for (int i = 31; i >= 0; i--) begin
      if (valid_mask[i] && !word_q[i]) begin
        found_c = 1'b1;
        fb_c = 5'(i);
      end
    end
  end

  assign st_too_large = req.request_size > 16'(sba_pkg::MaxSize);
  assign st_page_none = (page_r == '0);
  assign st_cls_match = (cls_q == cls_r);
  assign st_found = found_c;
  assign st_word_last = (9'({1'b0, word_r, 5'd0} + 9'd32) >= cnt) || (word_r == 3'd7);
  assign st_full = (used_r >= CW'(POOL_PAGES));
  assign st_claim_done = (word_r == 3'd7);

  always_comb begin
    c_we = 1'b0;
    c_waddr = (PW)'(used_r);
    c_wdata = cls_r;
    c_raddr = cur_page;
    b_we = 1'b0;
    b_waddr = BW'({cur_page, word_r});
    b_wdata = word_q | (32'd1 << bit_r);
    b_raddr = BW'({cur_page, word_r});
    if (cmd_load && req.operation == sba_pkg::OP_FREE) begin
      c_raddr = (PW)'(fpage);
    end
    if (cmd_claim) begin
      // A claimed page starts empty; the scan that follows takes its slot 0.
      b_we = 1'b1;
      b_waddr = BW'({(PW)'(used_r), word_r});
      b_wdata = 32'd0;
      c_we = (word_r == 3'd0);
    end else if (cmd_take) begin
      b_we = 1'b1;
    end else if (cmd_free) begin
      b_we = 1'b1;
      b_wdata = word_q & ~(32'd1 << fbit);
    end
  end

  always_comb begin
    used_nxt = used_r;
    if (cmd_claim && st_claim_done) used_nxt = used_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      used_r <= '0;
    end else begin
      if (cfg_we) base_r <= {cfg_data[31:12], 12'd0};
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_load) begin
      cls_r <= sba_pkg::class_of_size(req.request_size);
      faddr_r <= req.free_address;
    end
    if (cmd_load) begin
      page_r <= (req.operation == sba_pkg::OP_FREE) ? fpage + CW'(1) : used_r;
    end else if (cmd_next_page) begin
      page_r <= page_r - CW'(1);
    end else if (cmd_claim && st_claim_done) begin
      page_r <= used_r + CW'(1);
    end
    if (cmd_load || cmd_cls_rd || cmd_next_page) begin
      word_r <= '0;
    end else if (cmd_word_rd) begin
      word_r <= fslot[7:5];
    end else if ((cmd_eval && !found_c) || cmd_claim) begin
      word_r <= word_r + 3'd1;
    end
    if (cmd_eval && found_c) begin
      bit_r <= fb_c;
      slot_r <= 9'(base_slot + 9'(fb_c));
    end
    if (cmd_take) begin
      rsp.status <= sba_pkg::ST_ALLOCATED;
      rsp.address <= base_r + {(32 - PW - 12)'(0), cur_page, 12'd0}
                     + 32'(sba_pkg::DataOffset) + (32'(slot_r) << (4'd4 + 4'(cls_r)));
    end
    if (cmd_reject) begin
      rsp.status <= cmd_status;
      rsp.address <= '0;
    end
  end

endmodule

>>> hdl/sba_ctrl.sv
// Controller state machine sequencing the scan, claim and free steps of the slab allocator.
module sba_ctrl (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  logic       req_free,
  input  logic       st_too_large,
  input  logic       st_free_bad,
  input  logic       st_page_none,
  input  logic       st_cls_match,
  input  logic       st_found,
  input  logic       st_word_last,
  input  logic       st_full,
  input  logic       st_claim_done,
  output logic       cmd_load,
  output logic       cmd_cls_rd,
  output logic       cmd_word_rd,
  output logic       cmd_eval,
  output logic       cmd_next_page,
  output logic       cmd_claim,
  output logic       cmd_take,
  output logic       cmd_free,
  output logic       cmd_reject,
  output logic [2:0] cmd_status
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_PAGE   = 11'b00000000010,
    S_CLS    = 11'b00000000100,
    S_WRD    = 11'b00000001000,
    S_EVAL   = 11'b00000010000,
    S_CLAIM  = 11'b00000100000,
    S_TAKE   = 11'b00001000000,
    S_FCLS   = 11'b00010000000,
    S_FWRD   = 11'b00100000000,
    S_FCLR   = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE) && !(state_r == S_OUT && !out_stall) || 1'b0;
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd_load = 1'b0;
    cmd_cls_rd = 1'b0;
    cmd_word_rd = 1'b0;
    cmd_eval = 1'b0;
    cmd_next_page = 1'b0;
    cmd_claim = 1'b0;
    cmd_take = 1'b0;
    cmd_free = 1'b0;
    cmd_reject = 1'b0;
    cmd_status = sba_pkg::ST_ALLOCATED;
    case (state_r)
      S_IDLE, S_OUT: begin
        if (state_r == S_OUT && out_stall) begin
          state_nxt = S_OUT;
        end else if (in_valid) begin
          cmd_load = 1'b1;
          state_nxt = req_free ? S_FCLS : S_PAGE;
          if (!req_free && st_too_large) begin
            cmd_reject = 1'b1;
            cmd_status = sba_pkg::ST_TOO_LARGE;
            state_nxt = S_OUT;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PAGE: begin
        // Page pointer counts from pages in use down to zero.
        if (st_page_none) begin
          state_nxt = S_CLAIM;
          if (st_full) begin
            cmd_reject = 1'b1;
            cmd_status = sba_pkg::ST_EXHAUSTED;
            state_nxt = S_OUT;
          end
        end else begin
          cmd_cls_rd = 1'b1;
          state_nxt = S_CLS;
        end
      end
      S_CLS: begin
        if (st_cls_match) state_nxt = S_WRD;
        else begin
          cmd_next_page = 1'b1;
          state_nxt = S_PAGE;
        end
      end
      S_WRD: state_nxt = S_EVAL;
      S_EVAL: begin
        cmd_eval = 1'b1;
        if (st_found) state_nxt = S_TAKE;
        else if (st_word_last) begin
          cmd_next_page = 1'b1;
          state_nxt = S_PAGE;
        end else state_nxt = S_WRD;
      end
      S_CLAIM: begin
        // Once the new page is cleared, it is scanned like any other page.
        cmd_claim = 1'b1;
        if (st_claim_done) state_nxt = S_PAGE;
      end
      S_TAKE: begin
        cmd_take = 1'b1;
        state_nxt = S_OUT;
      end
      S_FCLS: begin
        if (st_free_bad) begin
          cmd_reject = 1'b1;
          cmd_status = sba_pkg::ST_BAD_ADDRESS;
          state_nxt = S_OUT;
        end else begin
          cmd_word_rd = 1'b1;
          cmd_status = sba_pkg::ST_FREED;
          state_nxt = S_FWRD;
        end
      end
      S_FWRD: state_nxt = S_FCLR;
      S_FCLR: begin
        cmd_free = 1'b1;
        cmd_reject = 1'b1;
        cmd_status = sba_pkg::ST_FREED;
        state_nxt = S_OUT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

>>> hdl/slab_bitmap_allocator_core.sv
// Top level of the slab bitmap allocator: controller plus datapath.
// Usage:
//   in_* carries one request (allocate with a byte size, or free with an
//   address); it is accepted when in_valid is high and in_stall is low.
//   out_* returns one result per request: address and status. The result
//   is taken when out_valid is high and out_stall is low.
//   cfg_* writes pool_base; the user must write it only while the block
//   is idle, as the block does not enforce it; its low 12 bits drop.
// Sequence from the accepting edge: a too-large allocate goes straight to
//   its result; a free checks its address, reads the bitmap word, clears
//   the bit and presents the result; a rejected free ends at the check.
//   An allocate visits pages newest first and reads each one's class; in a
//   page of its class it reads the bitmap words in turn through the single
//   read port, then sets the taken bit. If no page has room, the pool is
//   exhausted, or a new page's bitmap is cleared and its scan takes slot 0.
// Only one request is in flight. A result waiting under out_stall holds,
//   and a new request is taken in the cycle that the result leaves.
// Reset clears the pages-in-use count and pool_base; the memories need no
//   clearing, since a page is only read after its claim has written it.
module slab_bitmap_allocator_core #(
  parameter int POOL_PAGES = sba_pkg::PoolPagesDefault
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sba_pkg::req_t  in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output sba_pkg::rsp_t  out_rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [31:0]    cfg_data
);

  logic cmd_load, cmd_cls_rd, cmd_word_rd, cmd_eval, cmd_next_page;
  logic cmd_claim, cmd_take, cmd_free, cmd_reject;
  logic [2:0] cmd_status;
  logic st_too_large, st_free_bad, st_page_none, st_cls_match, st_found;
  logic st_word_last, st_full, st_claim_done;

  assign cfg_ready = 1'b1;

  sba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .req_free(in_req.operation),
    .st_too_large(st_too_large), .st_free_bad(st_free_bad),
    .st_page_none(st_page_none), .st_cls_match(st_cls_match),
    .st_found(st_found), .st_word_last(st_word_last),
    .st_full(st_full), .st_claim_done(st_claim_done),
    .cmd_load(cmd_load), .cmd_cls_rd(cmd_cls_rd), .cmd_word_rd(cmd_word_rd),
    .cmd_eval(cmd_eval), .cmd_next_page(cmd_next_page), .cmd_claim(cmd_claim),
    .cmd_take(cmd_take), .cmd_free(cmd_free), .cmd_reject(cmd_reject),
    .cmd_status(cmd_status));

  sba_datapath #(.POOL_PAGES(POOL_PAGES)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .cmd_load(cmd_load), .cmd_cls_rd(cmd_cls_rd), .cmd_word_rd(cmd_word_rd),
    .cmd_eval(cmd_eval), .cmd_next_page(cmd_next_page), .cmd_claim(cmd_claim),
    .cmd_take(cmd_take), .cmd_free(cmd_free), .cmd_reject(cmd_reject),
    .cmd_status(cmd_status), .req(in_req),
    .st_too_large(st_too_large), .st_free_bad(st_free_bad),
    .st_page_none(st_page_none), .st_cls_match(st_cls_match),
    .st_found(st_found), .st_word_last(st_word_last),
    .st_full(st_full), .st_claim_done(st_claim_done),
    .rsp(out_rsp));

endmodule
